/* rtl/core/bse_pkg.sv */
// shared types and constants for the bubble sort engine
`default_nettype none

package bse_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned CFG_AW  = 2;

  typedef logic signed [VALUE_W-1:0] value_t;

  localparam logic [CFG_AW-1:0] ADDR_DESCENDING = CFG_AW'(0);

  typedef struct packed {
    logic shift;
    logic sort;
    logic desc;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/bse_if.sv */
// valid/ready stream interfaces for the input and result channels
`default_nettype none

interface bse_in_if;
  logic             valid;
  logic             ready;
  bse_pkg::value_t  value;
  logic             last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface bse_out_if;
  logic             valid;
  logic             ready;
  bse_pkg::value_t  sorted_value;
  logic             last_out;

  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/bse_cell.sv */
// one sorter cell: holds a value, shifts down the chain or compare-swaps with a neighbour
`default_nettype none

module bse_cell (
  input  wire                       clk,
  input  wire bse_pkg::cell_ctrl_t  ctrl,
  input  wire                       pair_act,
  input  wire bse_pkg::value_t      upper_val,
  input  wire bse_pkg::value_t      lower_val,
  input  wire                       swap_lo,
  output bse_pkg::value_t           val,
  output logic                      swap_up
);
  import bse_pkg::*;

  value_t val_r;
  value_t val_nxt;
  logic   gt_up;
  logic   lt_up;

  assign lt_up = val_r < upper_val;
  assign gt_up = upper_val < val_r;

  assign swap_up = ctrl.sort && pair_act && (ctrl.desc ? lt_up : gt_up);

  always_comb begin
    val_nxt = val_r;
    if (ctrl.shift) begin
      val_nxt = upper_val;
    end else if (swap_up) begin
      val_nxt = upper_val;
    end else if (ctrl.sort && swap_lo) begin
      val_nxt = lower_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

/* rtl/core/bubble_sort_engine_core.sv */
// bubble sort engine top level: load chain, odd-even transposition sort, ordered emit
//
//  channel  | direction | handshake       | payload
//  ---------+-----------+-----------------+-----------------------------------
//  in_ch    | in        | valid / ready   | value (s32), last_in
//  out_ch   | out       | valid / ready   | sorted_value (s32), last_out
//  cfg_*    | in        | apb, pready = 1 | descending at 0x0, bit 0
//
//  a set of n items loads at one item per cycle, then runs n compare-swap phases
//  across the cell chain, then emits its n results in order through the output register;
//  intake stays closed while the set sorts and emits
//  no item is accepted from set close until the final result enters the output register
//  rst_n is synchronous; the cell chain holds no reset, only control state clears
//  a stalled sink holds the emit shift for as long as the output register is full
`default_nettype none

module bubble_sort_engine_core #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  bse_in_if.sink                       in_ch,
  bse_out_if.source                    out_ch,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire [bse_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire [bse_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [bse_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import bse_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ITEMS - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             par_r, par_nxt;
  logic             desc_r, desc_nxt;
  logic             desc_run_r, desc_run_nxt;
  logic             out_valid_r, out_valid_nxt;
  value_t           out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_fire;
  logic             emit_fire;
  logic             cfg_wr;
  logic [IDX_W-1:0] base;
  cell_ctrl_t       ctrl;

  value_t           cell_val [MAX_ITEMS];
  logic             cell_swap [MAX_ITEMS];

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign emit_fire   = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign base        = IDX_W'(CNT_MAX - cnt_r);

  assign ctrl.shift = in_fire || emit_fire;
  assign ctrl.sort  = (state_r == ST_SORT);
  assign ctrl.desc  = desc_run_r;

  // cell chain, cell MAX_ITEMS-1 takes new items, head of the set sits at base
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    logic   pair_act;
    value_t upper_val;
    value_t lower_val;
    logic   swap_lo;

    if (k == MAX_ITEMS - 1) begin : g_top
      assign pair_act  = 1'b0;
      assign upper_val = in_ch.value;
    end else begin : g_mid
      assign pair_act  = (1'(k) == par_r) && (IDX_W'(k) >= base);
      assign upper_val = cell_val[k+1];
    end

    if (k == 0) begin : g_bot
      assign lower_val = cell_val[0];
      assign swap_lo   = 1'b0;
    end else begin : g_low
      assign lower_val = cell_val[k-1];
      assign swap_lo   = cell_swap[k-1];
    end

    bse_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .pair_act  (pair_act),
      .upper_val (upper_val),
      .lower_val (lower_val),
      .swap_lo   (swap_lo),
      .val       (cell_val[k]),
      .swap_up   (cell_swap[k])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    remain_nxt    = remain_r;
    par_nxt       = par_r;
    desc_run_nxt  = desc_run_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          cnt_nxt = cnt_r + CNT_ONE;
          if (in_ch.last_in || (cnt_r == CNT_LAST)) begin
            state_nxt    = ST_SORT;
            phase_nxt    = '0;
            par_nxt      = 1'b0;
            desc_run_nxt = desc_r;
          end
        end
      end
      ST_SORT: begin
        phase_nxt = phase_r + CNT_ONE;
        par_nxt   = !par_r;
        if (phase_r == cnt_r - CNT_ONE) begin
          state_nxt  = ST_EMIT;
          remain_nxt = cnt_r;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = cell_val[base];
          out_last_nxt  = (remain_r == CNT_ONE);
          remain_nxt    = remain_r - CNT_ONE;
          if (remain_r == CNT_ONE) begin
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        cnt_nxt   = '0;
      end
    endcase
  end

  // configuration
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign desc_nxt   = (cfg_wr && (cfg_paddr == ADDR_DESCENDING)) ? cfg_pwdata[0] : desc_r;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == ADDR_DESCENDING) begin
      cfg_prdata[0] = desc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      phase_r     <= '0;
      remain_r    <= '0;
      par_r       <= 1'b0;
      desc_r      <= 1'b0;
      desc_run_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      remain_r    <= remain_nxt;
      par_r       <= par_nxt;
      desc_r      <= desc_nxt;
      desc_run_r  <= desc_run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_value_r;
  assign out_ch.last_out     = out_last_r;

endmodule

`default_nettype wire

/* rtl/core/bse_checker.sv */
// port-level checks for the bubble sort engine, bound to the top level
`default_nettype none

module bse_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_valid,
  input wire                    in_ready,
  input wire                    in_last,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire bse_pkg::value_t   out_value,
  input wire                    out_last,
  input wire                    cfg_pready
);
  import bse_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("result changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a set closed by last stops intake while it sorts
  a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("intake open after set close");

  // register port never stalls
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind bubble_sort_engine_core bse_checker u_bse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.last_in),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.sorted_value),
  .out_last   (out_ch.last_out),
  .cfg_pready (cfg_pready)
);

`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench for the bubble sort engine core: directed table, then random sets
`timescale 1ns / 1ps

module tb_top;
  import bse_pkg::*;

  localparam int unsigned MAX_ITEMS  = 16;
  localparam int unsigned SETTLE     = 3 * MAX_ITEMS + 16;
  localparam int unsigned RAND_ITEMS = 216;
  localparam value_t      V_MIN      = 32'sh8000_0000;
  localparam value_t      V_MAX      = 32'sh7FFF_FFFF;

  typedef struct packed {
    value_t value;
    logic   last;
  } sorted_t;

  typedef struct packed {
    value_t            value;
    logic              last_in;
    logic              typed;
    value_t            typed_value;
    logic              cfg_first;
    logic [CFG_DW-1:0] cfg_word;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  bse_in_if  in_ch ();
  bse_out_if out_ch ();

  bubble_sort_engine_core #(
    .MAX_ITEMS (MAX_ITEMS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  value_t      held [MAX_ITEMS];
  int unsigned held_cnt;
  logic        desc_now;
  sorted_t     sorted_due [$];
  sorted_t     fresh_sorted [$];
  stim_row_t   dir_rows [$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned sets_closed;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        typed_due;
  value_t      typed_value;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", sorted_due.size());
    $display("** bubble_sort_engine_core: FAILED **");
    $finish;
  end

  // store one value; on set close sort by adjacent strict compare-swap passes
  task automatic load_and_sort(input value_t v, input logic last);
    value_t      tmp;
    int unsigned n;
    logic        swap;
    fresh_sorted.delete();
    held[held_cnt] = v;
    held_cnt++;
    if (!last && held_cnt < MAX_ITEMS) return;
    n = held_cnt;
    for (int unsigned pass = 0; pass < n; pass++) begin
      for (int unsigned i = 0; i + 1 < n; i++) begin
        swap = desc_now ? (held[i] < held[i+1]) : (held[i+1] < held[i]);
        if (swap) begin
          tmp       = held[i];
          held[i]   = held[i+1];
          held[i+1] = tmp;
        end
      end
    end
    for (int unsigned k = 0; k < n; k++) begin
      fresh_sorted.push_back('{held[k], (k + 1 == n)});
    end
    held_cnt = 0;
  endtask

  always @(posedge clk) begin : watch_channels
    sorted_t exp_r;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      load_and_sort(in_ch.value, in_ch.last_in);
      if (fresh_sorted.size() != 0) sets_closed++;
      if (typed_due) begin
        typed_due = 1'b0;
        sorted_due.push_back('{typed_value, 1'b1});
      end else begin
        foreach (fresh_sorted[k]) sorted_due.push_back(fresh_sorted[k]);
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (sorted_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, got %0d last %0b", $time,
                 out_ch.sorted_value, out_ch.last_out);
      end else begin
        exp_r = sorted_due.pop_front();
        if (out_ch.sorted_value !== exp_r.value) begin
          errors++;
          $display("%0t: sorted_value expected %0d got %0d", $time, exp_r.value,
                   out_ch.sorted_value);
        end
        if (out_ch.last_out !== exp_r.last) begin
          errors++;
          $display("%0t: last_out expected %0b got %0b", $time, exp_r.last,
                   out_ch.last_out);
        end
      end
    end
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic push_item(input value_t v, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.last_in <= l;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sorted_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // write then read back the order register
  task automatic cfg_write(input logic [CFG_DW-1:0] word);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_DESCENDING;
    cfg_pwdata  <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    desc_now = word[0];
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DW'(desc_now)) begin
      errors++;
      $display("%0t: descending read expected %0h got %0h", $time, CFG_DW'(desc_now),
               cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic add_row(input value_t v, input logic l, input logic typed, input value_t tv,
                         input logic cfg_first, input logic [CFG_DW-1:0] word);
    dir_rows.push_back('{v, l, typed, tv, cfg_first, word});
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return V_MIN;
      1:       return V_MAX;
      2, 3:    return value_t'(int'($urandom_range(6)) - 3);
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic random_set();
    int unsigned n;
    logic        open_end;
    open_end = 1'b0;
    case ($urandom_range(9))
      0:       n = 1;
      1: begin
        n        = MAX_ITEMS;
        open_end = 1'b1;
      end
      2:       n = MAX_ITEMS;
      default: n = $urandom_range(MAX_ITEMS - 1, 2);
    endcase
    for (int unsigned k = 0; k < n; k++) begin
      push_item(pick_value(), (k + 1 == n) && !open_end);
    end
  endtask

  initial begin : main
    int unsigned       start;
    logic [CFG_DW-1:0] word;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    in_ch.last_in  = 1'b0;
    out_ch.ready   = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    held_cnt       = 0;
    desc_now       = 1'b0;
    errors         = 0;
    items_sent     = 0;
    results_seen   = 0;
    sets_closed    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    typed_due      = 1'b0;
    typed_value    = '0;

    // single-element sets at the extremes, then a four-item set holding both extremes
    add_row(V_MIN, 1'b1, 1'b1, V_MIN, 1'b0, '0);
    add_row(V_MAX, 1'b1, 1'b1, V_MAX, 1'b0, '0);
    add_row(V_MAX, 1'b0, 1'b0, '0, 1'b0, '0);
    add_row(-1,    1'b0, 1'b0, '0, 1'b0, '0);
    add_row(V_MIN, 1'b0, 1'b0, '0, 1'b0, '0);
    add_row(0,     1'b1, 1'b0, '0, 1'b0, '0);
    // order changed while a set is half loaded
    add_row(10,    1'b0, 1'b0, '0, 1'b0, '0);
    add_row(-10,   1'b0, 1'b0, '0, 1'b0, '0);
    add_row(10,    1'b1, 1'b0, '0, 1'b1, 32'h0000_0001);
    add_row(42,    1'b1, 1'b1, 42, 1'b0, '0);
    // full store closes the set without last, only bit 0 of the write counts
    for (int i = 0; i < MAX_ITEMS; i++) begin
      add_row((i == 7) ? V_MAX : (i == 11) ? V_MIN : value_t'((i % 4) * -5), 1'b0, 1'b0, '0,
              (i == 0), 32'hFFFF_FFFE);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_first) begin
        settle();
        cfg_write(dir_rows[i].cfg_word);
      end
      if (dir_rows[i].typed) begin
        typed_value = dir_rows[i].typed_value;
        typed_due   = 1'b1;
      end
      push_item(dir_rows[i].value, dir_rows[i].last_in);
    end

    for (int p = 0; p < 4; p++) begin
      settle();
      word    = $urandom;
      word[0] = ~p[0];
      cfg_write(word);
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 45;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 45;
        end
        default: begin
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
      endcase
      start = items_sent;
      while (items_sent - start < RAND_ITEMS / 4) random_set();
    end

    settle();
    $display("covered %0d items in %0d sets, %0d sorted results checked", items_sent,
             sets_closed, results_seen);
    $display("both sort orders, full-store closes and four idle and stall mixes exercised");
    if (errors == 0) begin
      $display("** bubble_sort_engine_core: PASSED **");
    end else begin
      $display("** bubble_sort_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
